/* rtl/core/gf13_pkg.sv */
// ----------------------------------------------------------------------------
// gf13_pkg
// Types, codes, microcode and the field multiplier shared by the GF(2^13)
// arithmetic unit.
// ----------------------------------------------------------------------------
package gf13_pkg;

    localparam int unsigned FIELD_W = 13;
    localparam int unsigned EXP_W   = 32;
    localparam int unsigned PROD_W  = 2 * FIELD_W - 1;

    typedef logic [FIELD_W-1:0] elem_t;

    // Operation codes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_MUL = 3'd1;
    localparam logic [2:0] OP_INV = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;

    // Exponent that turns a power into an inverse: 2^13 - 2
    localparam logic [EXP_W-1:0] INV_EXP = 32'd8190;

    localparam elem_t ELEM_ZERO = 13'd0;
    localparam elem_t ELEM_ONE  = 13'd1;

    // x^13 .. x^24 reduced modulo x^13 + x^4 + x^3 + x + 1
    localparam elem_t RED_TBL [FIELD_W-1] = '{
        13'h001B, 13'h0036, 13'h006C, 13'h00D8, 13'h01B0, 13'h0360,
        13'h06C0, 13'h0D80, 13'h1B00, 13'h161B, 13'h0C2D, 13'h185A
    };

    // Microcode step addresses
    typedef logic [3:0] step_t;
    localparam step_t S_IDLE     = 4'd0;
    localparam step_t S_DISPATCH = 4'd1;
    localparam step_t S_ADD      = 4'd2;
    localparam step_t S_MUL      = 4'd3;
    localparam step_t S_LOOP     = 4'd4;
    localparam step_t S_SQR      = 4'd5;
    localparam step_t S_FIN      = 4'd6;
    localparam step_t S_MULA     = 4'd7;
    localparam step_t S_DONE     = 4'd8;
    localparam step_t S_ZERO     = 4'd9;
    localparam step_t S_ONE      = 4'd10;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_LOAD,
        UOP_SETUP,
        UOP_XOR,
        UOP_MULAB,
        UOP_MULRB,
        UOP_SQR,
        UOP_MULA,
        UOP_SET0,
        UOP_SET1,
        UOP_OUT
    } uop_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_INPUT,
        COND_OUTPUT,
        COND_ENZ,
        COND_NDIV,
        COND_DISPATCH
    } cond_t;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        step_t target;
    } ctl_word_t;

    // Program ROM
    function automatic ctl_word_t ucode_rom(input step_t pc);
        ctl_word_t cw;
        case (pc)
            S_IDLE:     cw = '{UOP_LOAD,  COND_INPUT,    S_DISPATCH};
            S_DISPATCH: cw = '{UOP_SETUP, COND_DISPATCH, S_IDLE};
            S_ADD:      cw = '{UOP_XOR,   COND_JUMP,     S_DONE};
            S_MUL:      cw = '{UOP_MULAB, COND_JUMP,     S_DONE};
            S_LOOP:     cw = '{UOP_MULRB, COND_NEXT,     S_SQR};
            S_SQR:      cw = '{UOP_SQR,   COND_ENZ,      S_LOOP};
            S_FIN:      cw = '{UOP_NOP,   COND_NDIV,     S_DONE};
            S_MULA:     cw = '{UOP_MULA,  COND_NEXT,     S_DONE};
            S_DONE:     cw = '{UOP_OUT,   COND_OUTPUT,   S_IDLE};
            S_ZERO:     cw = '{UOP_SET0,  COND_JUMP,     S_DONE};
            S_ONE:      cw = '{UOP_SET1,  COND_JUMP,     S_DONE};
            default:    cw = '{UOP_NOP,   COND_JUMP,     S_IDLE};
        endcase
        return cw;
    endfunction

    // Carry-less multiply, then fold the high product bits with RED_TBL
    function automatic elem_t gf_mul(input elem_t x, input elem_t y);
        logic [PROD_W-1:0] prod;
        elem_t             acc;
        prod = '0;
        for (int i = 0; i < FIELD_W; i++)
        begin
            if (y[i])
            begin
                prod = prod ^ (PROD_W'(x) << i);
            end
        end
        acc = prod[FIELD_W-1:0];
        for (int k = 0; k < FIELD_W - 1; k++)
        begin
            if (prod[FIELD_W + k])
            begin
                acc = acc ^ RED_TBL[k];
            end
        end
        return acc;
    endfunction

endpackage

/* rtl/core/gf8192_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// gf8192_arithmetic_unit
// One GF(2^13) operation per transfer: add, multiply, inverse, divide, power.
// ----------------------------------------------------------------------------
// The unit takes one item at a time and returns one 13-bit field element per
// item, reduced modulo x^13 + x^4 + x^3 + x + 1. A small microcode program
// drives a datapath built around a single shared field multiplier. Add and
// multiply pass through the dispatch, compute and done steps, and the result
// is then registered and raised valid. Inverse and divide run a
// square-and-multiply over the 13-bit exponent 8190, a multiply step and a
// square step per exponent bit, and divide adds a final multiply. Power runs
// the same two steps per bit up to the top set bit of the exponent, at most
// 31 bits. Special cases (zero operands, zero or negative exponents, unused
// codes) load a constant and go straight to the done step. Each item also
// spends one idle step waiting for its transfer, and a result that the
// receiver stalls holds the done step until the output register frees up.
// The result sits in an output register, so the next input transfer is
// taken while an earlier result is still waiting.
// ----------------------------------------------------------------------------
module gf8192_arithmetic_unit
    import gf13_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           operation,
    input  logic [FIELD_W-1:0]   operand_a,
    input  logic [FIELD_W-1:0]   operand_b,
    input  logic signed [EXP_W-1:0] exponent,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [FIELD_W-1:0]   result
);

    // Step counter and current control word
    step_t     pc_reg;
    step_t     pc_next;
    ctl_word_t cw;

    // Datapath registers
    logic [2:0]       op_reg;
    elem_t            a_reg;
    elem_t            b_reg;
    elem_t            r_reg;
    logic [EXP_W-1:0] e_reg;

    // Output register
    logic  out_valid_reg;
    elem_t result_reg;

    logic  in_fire;
    logic  out_free;
    step_t dispatch_step;
    elem_t mul_x;
    elem_t mul_y;
    elem_t mul_p;

    assign cw       = ucode_rom(pc_reg);
    assign in_ready = (pc_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    // The output register can take a new result when empty or draining now
    assign out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // Entry point per operation, with the special cases routed straight to
    // a constant load.
    always_comb
    begin
        case (op_reg)
            OP_ADD: dispatch_step = S_ADD;
            OP_MUL: dispatch_step = S_MUL;
            OP_INV: dispatch_step = (a_reg == ELEM_ZERO) ? S_ZERO : S_LOOP;
            OP_DIV:
            begin
                if (a_reg == ELEM_ZERO || b_reg == ELEM_ZERO)
                    dispatch_step = S_ZERO;
                else
                    dispatch_step = S_LOOP;
            end
            OP_POW:
            begin
                if (e_reg == '0)
                    dispatch_step = S_ONE;
                else if (a_reg == ELEM_ZERO)
                    dispatch_step = S_ZERO;
                else if (e_reg[EXP_W-1])
                    dispatch_step = S_ONE;
                else
                    dispatch_step = S_LOOP;
            end
            default: dispatch_step = S_ZERO;
        endcase
    end

    // Sequencer: advance, jump, or hold on a handshake
    always_comb
    begin
        case (cw.cond)
            COND_NEXT:     pc_next = pc_reg + 4'd1;
            COND_JUMP:     pc_next = cw.target;
            COND_INPUT:    pc_next = in_fire ? cw.target : pc_reg;
            COND_OUTPUT:   pc_next = out_free ? cw.target : pc_reg;
            COND_ENZ:      pc_next = (e_reg[EXP_W-1:1] != '0) ? cw.target : pc_reg + 4'd1;
            COND_NDIV:     pc_next = (op_reg != OP_DIV) ? cw.target : pc_reg + 4'd1;
            COND_DISPATCH: pc_next = dispatch_step;
            default:       pc_next = S_IDLE;
        endcase
    end

    // Operand select for the shared multiplier
    always_comb
    begin
        case (cw.uop)
            UOP_MULAB:
            begin
                mul_x = a_reg;
                mul_y = b_reg;
            end
            UOP_MULRB:
            begin
                mul_x = r_reg;
                mul_y = b_reg;
            end
            UOP_SQR:
            begin
                mul_x = b_reg;
                mul_y = b_reg;
            end
            default:
            begin
                mul_x = r_reg;
                mul_y = a_reg;
            end
        endcase
    end

    assign mul_p = gf_mul(mul_x, mul_y);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (cw.uop == UOP_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers, written as the control word says
    always_ff @(posedge clk)
    begin
        case (cw.uop)
            UOP_LOAD:
            begin
                // Capture the item on its input transfer
                if (in_fire)
                begin
                    op_reg <= operation;
                    a_reg  <= operand_a;
                    b_reg  <= operand_b;
                    e_reg  <= exponent;
                end
            end
            UOP_SETUP:
            begin
                // Base goes to b_reg; inverse and divide use exponent 8190
                r_reg <= ELEM_ONE;
                case (op_reg)
                    OP_INV:
                    begin
                        b_reg <= a_reg;
                        e_reg <= INV_EXP;
                    end
                    OP_DIV: e_reg <= INV_EXP;
                    OP_POW: b_reg <= a_reg;
                    default: ;
                endcase
            end
            UOP_XOR:   r_reg <= a_reg ^ b_reg;
            UOP_MULAB: r_reg <= mul_p;
            UOP_MULRB:
            begin
                if (e_reg[0])
                    r_reg <= mul_p;
            end
            UOP_SQR:
            begin
                b_reg <= mul_p;
                e_reg <= e_reg >> 1;
            end
            UOP_MULA:  r_reg <= mul_p;
            UOP_SET0:  r_reg <= ELEM_ZERO;
            UOP_SET1:  r_reg <= ELEM_ONE;
            UOP_OUT:
            begin
                if (out_free)
                    result_reg <= r_reg;
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> pc_reg == S_DISPATCH)
        else $error("input transfer not followed by dispatch");

    a_loop_exp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == S_LOOP |-> e_reg != '0)
        else $error("square-and-multiply step with zero exponent");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pc_reg) == S_DONE)
        else $error("result presented outside the done step");

    a_add_result: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == S_ADD |=> r_reg == $past(a_reg ^ b_reg))
        else $error("add step wrote a wrong sum");
`endif

endmodule

/* sim/gf13_result_checker.sv */
// ----------------------------------------------------------------------------
// gf13_result_checker
// Watches both channels of the GF(2^13) arithmetic unit and checks each
// returned element against an independent prediction made at input transfer.
// ----------------------------------------------------------------------------
module gf13_result_checker
    import gf13_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [2:0]              operation,
    input  logic [FIELD_W-1:0]      operand_a,
    input  logic [FIELD_W-1:0]      operand_b,
    input  logic signed [EXP_W-1:0] exponent,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [FIELD_W-1:0]      result,
    output int                      fail_count,
    output int                      outstanding,
    output int                      compared
);
    timeunit 1ns;
    timeprecision 1ps;

    // x^13 + x^4 + x^3 + x + 1, with the x^13 term kept for the reduction step
    localparam logic [FIELD_W:0] FIELD_POLY  = 14'h201B;
    // a^(2^13 - 2) is the inverse of a nonzero a
    localparam logic [EXP_W-1:0] INVERSE_EXP = 32'd8190;

    typedef struct {
        logic [2:0]       op;
        elem_t            a;
        elem_t            b;
        logic [EXP_W-1:0] e;
        elem_t            value;
    } prediction_t;

    prediction_t predicted_elements[$];

    // Shift-and-add multiply, reducing after every doubling of the multiplicand
    function automatic elem_t field_product(input elem_t x, input elem_t y);
        logic [FIELD_W:0] shifted;
        elem_t            acc;
        shifted = {1'b0, x};
        acc     = '0;
        for (int i = 0; i < FIELD_W; i++)
        begin
            if (y[i])
            begin
                acc = acc ^ shifted[FIELD_W-1:0];
            end
            shifted = shifted << 1;
            if (shifted[FIELD_W])
            begin
                shifted = shifted ^ FIELD_POLY;
            end
        end
        return acc;
    endfunction

    function automatic elem_t field_power(input elem_t base, input logic [EXP_W-1:0] e);
        elem_t acc;
        elem_t sq;
        acc = ELEM_ONE;
        sq  = base;
        for (int i = 0; i < EXP_W; i++)
        begin
            if (e[i])
            begin
                acc = field_product(acc, sq);
            end
            sq = field_product(sq, sq);
        end
        return acc;
    endfunction

    function automatic elem_t field_inverse(input elem_t a);
        if (a == ELEM_ZERO)
        begin
            return ELEM_ZERO;
        end
        return field_power(a, INVERSE_EXP);
    endfunction

    function automatic elem_t gf13_evaluate(input logic [2:0] op, input elem_t a,
                                            input elem_t b, input logic [EXP_W-1:0] e);
        case (op)
            OP_ADD: return a ^ b;
            OP_MUL: return field_product(a, b);
            OP_INV: return field_inverse(a);
            OP_DIV:
            begin
                if (a == ELEM_ZERO || b == ELEM_ZERO)
                begin
                    return ELEM_ZERO;
                end
                return field_product(a, field_inverse(b));
            end
            OP_POW:
            begin
                if (e == '0)
                begin
                    return ELEM_ONE;
                end
                if (a == ELEM_ZERO)
                begin
                    return ELEM_ZERO;
                end
                if (e[EXP_W-1])
                begin
                    return ELEM_ONE;
                end
                return field_power(a, e);
            end
            default: return ELEM_ZERO;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        prediction_t head;
        prediction_t fresh;
        if (!rst_n)
        begin
            predicted_elements.delete();
            outstanding = 0;
        end
        else
        begin
            // retire first so a same-cycle input never matches itself
            if (out_valid && out_ready)
            begin
                if (predicted_elements.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    $display("%0t: result %h arrived with nothing outstanding", $realtime, result);
                end
                else
                begin
                    head     = predicted_elements.pop_front();
                    compared = compared + 1;
                    if (result !== head.value)
                    begin
                        fail_count = fail_count + 1;
                        $display("%0t: op %0d a=%h b=%h exp=%h: expected %h, actual %h",
                                 $realtime, head.op, head.a, head.b, head.e,
                                 head.value, result);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                fresh.op    = operation;
                fresh.a     = operand_a;
                fresh.b     = operand_b;
                fresh.e     = exponent;
                fresh.value = gf13_evaluate(operation, operand_a, operand_b, exponent);
                predicted_elements.push_back(fresh);
            end
            outstanding = predicted_elements.size();
        end
    end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the GF(2^13) arithmetic unit.
// ----------------------------------------------------------------------------
// A directed set covers the edges of every operation (zero and all-ones
// operands, zero and negative exponents, two of the spare opcodes); then a long
// random run mixes all operations with bursty idling on both channels.
// The checker beside the unit predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module testbench
    import gf13_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1300;
    // last stretch of the run goes without any idling
    localparam int CALM_TAIL    = 150;
    // worst case is the longest power plus the widest idle gaps on each side per
    // item; allow several times that
    localparam int CYCLE_LIMIT  = 1000000;
    // wait past the longest power for any stray result
    localparam int DRAIN_CYCLES = 100;
    localparam int PAUSE_AT     = 650;

    // opcodes the unit does not define; they must return zero
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [2:0]              operation;
    logic [FIELD_W-1:0]      operand_a;
    logic [FIELD_W-1:0]      operand_b;
    logic signed [EXP_W-1:0] exponent;
    logic                    out_valid;
    logic                    out_ready;
    logic [FIELD_W-1:0]      result;

    int fail_count;
    int outstanding;
    int compared;
    int cycle_count;
    int sent_count;
    int op_tally [8];
    // idling odds in percent per opportunity; zero turns idling off
    int tx_gap_pct;
    int rx_stall_pct;

    gf8192_arithmetic_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .exponent  (exponent),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    gf13_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .operand_a   (operand_a),
        .operand_b   (operand_b),
        .exponent    (exponent),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result      (result),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .compared    (compared)
    );

    always #2 clk = ~clk;

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: no progress after %0d cycles", $realtime, cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Bias operands toward 0, 1 and all-ones, where the special cases live
    function automatic elem_t pick_element();
        case ($urandom_range(0, 19))
            0:       return ELEM_ZERO;
            1:       return ELEM_ONE;
            2:       return 13'h1FFF;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // Mix zero, negative, small, group-order multiples and full-width values
    function automatic logic signed [EXP_W-1:0] pick_exponent();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return {1'b1, 31'($urandom)};
            3, 4:    return EXP_W'($urandom_range(1, 64));
            5:       return EXP_W'(8191 * $urandom_range(1, 1000) + $urandom_range(0, 2));
            6:       return $urandom;
            default: return {1'b0, 31'($urandom)};
        endcase
    endfunction

    // Power gets the largest share since it has the most internal paths
    function automatic logic [2:0] pick_operation();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 14)      return OP_ADD;
        else if (roll < 32) return OP_MUL;
        else if (roll < 47) return OP_INV;
        else if (roll < 64) return OP_DIV;
        else if (roll < 95) return OP_POW;
        else                return 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    endfunction

    // Present one item and hold it until the transfer; call at a falling edge
    task automatic send_item(input logic [2:0] op, input elem_t a, input elem_t b,
                             input logic signed [EXP_W-1:0] e);
        in_valid  <= 1'b1;
        operation <= op;
        operand_a <= a;
        operand_b <= b;
        exponent  <= e;
        op_tally[op] = op_tally[op] + 1;
        sent_count   = sent_count + 1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Maybe drop valid for a burst; scramble the idle payload meanwhile
    task automatic sender_gap();
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
        begin
            in_valid  <= 1'b0;
            operation <= 3'($urandom);
            operand_a <= FIELD_W'($urandom);
            operand_b <= FIELD_W'($urandom);
            exponent  <= $urandom;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    // Hold the sender off until every prediction has been retired
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 8;
            default: return 25;
        endcase
    endfunction

    // Receiver: ready high by default, dropped in random bursts
    initial
    begin : receiver
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = OP_ADD;
        operand_a    = '0;
        operand_b    = '0;
        exponent     = '0;
        sent_count   = 0;
        tx_gap_pct   = 10;
        rx_stall_pct = 10;
        foreach (op_tally[i])
        begin
            op_tally[i] = 0;
        end

        // Hold reset, then release it away from the rising edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: add at the extremes
        send_item(OP_ADD, 13'h0000, 13'h0000, 32'sd0);
        send_item(OP_ADD, 13'h1FFF, 13'h1FFF, -32'sd1);
        send_item(OP_ADD, 13'h1FFF, 13'h0000, 32'sd5);
        // multiply: top bits set on both sides exercise the even-power reduction terms
        send_item(OP_MUL, 13'h1FFF, 13'h1FFF, 32'sd0);
        send_item(OP_MUL, 13'h0000, 13'h1FFF, 32'sd0);
        send_item(OP_MUL, 13'h0001, 13'h1AAA, 32'sd0);
        send_item(OP_MUL, 13'h1000, 13'h1000, 32'sd0);
        // inverse, including zero which maps to zero
        send_item(OP_INV, 13'h0000, 13'h1FFF, 32'sd3);
        send_item(OP_INV, 13'h0001, 13'h0000, 32'sd0);
        send_item(OP_INV, 13'h1FFF, 13'h0000, 32'sd0);
        send_item(OP_INV, 13'h0002, 13'h0000, 32'sd0);
        // divide by zero, zero dividend, self-division
        send_item(OP_DIV, 13'h1234, 13'h0000, 32'sd0);
        send_item(OP_DIV, 13'h0000, 13'h1234, 32'sd0);
        send_item(OP_DIV, 13'h1FFF, 13'h1FFF, 32'sd0);
        send_item(OP_DIV, 13'h0001, 13'h1FFF, 32'sd0);
        // power: zero exponent wins over zero base; negatives collapse
        send_item(OP_POW, 13'h0000, 13'h1FFF, 32'sd0);
        send_item(OP_POW, 13'h1ABC, 13'h0000, 32'sd0);
        send_item(OP_POW, 13'h0000, 13'h0000, 32'sd5);
        send_item(OP_POW, 13'h0000, 13'h0000, -32'sd7);
        send_item(OP_POW, 13'h1ABC, 13'h0000, -32'sd1);
        send_item(OP_POW, 13'h1ABC, 13'h0000, 32'sh7FFFFFFF);
        send_item(OP_POW, 13'h0002, 13'h0000, 32'sh80000000);
        send_item(OP_POW, 13'h0002, 13'h0000, 32'sd8191);
        // spare opcodes with live operands must still return zero
        send_item(OP_SPARE_LO, 13'h1FFF, 13'h1FFF, -32'sd1);
        send_item(OP_SPARE_HI, 13'h1555, 13'h0AAA, 32'sd9);

        // Let the directed set settle before the random run
        wait_for_drain();
        @(negedge clk);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // re-roll the idling profile every 200 items, calm at the end
            if (n >= RANDOM_ITEMS - CALM_TAIL)
            begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            else if (n % 200 == 0)
            begin
                tx_gap_pct   = pick_idle_pct();
                rx_stall_pct = pick_idle_pct();
            end
            if (n == PAUSE_AT)
            begin
                wait_for_drain();
                @(negedge clk);
            end
            send_item(pick_operation(), pick_element(), pick_element(), pick_exponent());
            sender_gap();
        end

        // Drain, then linger for any result that should not come
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d transfers: add %0d, mul %0d, inv %0d, div %0d, pow %0d,",
                 sent_count, op_tally[OP_ADD], op_tally[OP_MUL], op_tally[OP_INV],
                 op_tally[OP_DIV], op_tally[OP_POW]);
        $display("spare opcodes %0d; %0d results compared, %0d failures",
                 op_tally[OP_SPARE_LO] + op_tally[OP_SPARE_MID] + op_tally[OP_SPARE_HI],
                 compared, fail_count);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
